// ----- sv/dfs_pkg.sv -----
package dfs_pkg;

    // Address space of the node fields and the stack
    localparam int ADDR_NODES = 32;
    localparam int NODE_W     = 5;
    localparam int CNT_W      = 6;

    // Operation codes
    localparam logic [1:0] FN_ADD    = 2'd0;
    localparam logic [1:0] FN_SEARCH = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_PATH  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_EMIT,
        S_REPORT
    } state_t;

endpackage

// ----- sv/dfs_path_search_adjacency_matrix.sv -----
// Path search over an undirected graph of up to 32 nodes, kept as an adjacency bit
// matrix in flip-flops (cleared at reset and by the clear operation). Add-edge and
// clear transactions give no result, except an add-edge with an index out of
// range. A search first seeds the stack with its start node, then in turn pops a
// node and scans that node's row over every live node, since a single compare unit
// tests one neighbour a cycle, until a pop finds the target or an empty stack.
// The path is then sent from target back to start, one node a cycle while the
// output side takes them. The input side is not ready until the last result of a
// search has been loaded into the output register. Configuration writes
// (node_count) are always taken and must only be made while the block is idle.
module dfs_path_search_adjacency_matrix
    import dfs_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    // input transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [NODE_W-1:0] s_node_a,
    input  logic [NODE_W-1:0] s_node_b,
    // result transactions
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [NODE_W-1:0] m_path_node,
    output logic              m_last
);

    localparam int         LIMIT   = (MAX_NODES < ADDR_NODES) ? MAX_NODES : ADDR_NODES;
    localparam logic [CNT_W-1:0] LIMIT_N = CNT_W'(LIMIT);
    localparam logic [CNT_W-1:0] STACK_N = CNT_W'(ADDR_NODES);
    localparam logic [NODE_W-1:0] K_MAX  = NODE_W'(ADDR_NODES - 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]      node_count_reg;
    logic [ADDR_NODES-1:0] adj_reg [ADDR_NODES];
    logic [ADDR_NODES-1:0] explored_reg;
    logic [ADDR_NODES-1:0] pred_valid_reg;
    logic [NODE_W-1:0]     pred_idx_reg [ADDR_NODES];
    logic [NODE_W-1:0]     stack_reg [ADDR_NODES];
    logic [CNT_W-1:0]      count_reg;
    logic [NODE_W-1:0]     cur_reg;
    logic [NODE_W-1:0]     start_reg;
    logic [NODE_W-1:0]     target_reg;
    logic                  popped_reg;
    logic [NODE_W-1:0]     idx_reg;
    logic [NODE_W-1:0]     k_reg;
    logic                  tail_reg;
    logic [1:0]            rep_status_reg;

    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [NODE_W-1:0]     m_node_reg;
    logic                  m_last_reg;

    logic [CNT_W-1:0]      live_n;
    logic                  accept_in;
    logic                  idx_ok;
    logic                  found;
    logic                  pop_done;
    logic                  push_ok;
    logic                  scan_last;
    logic                  out_free;
    logic                  emit_more;

    logic                  out_load;
    logic [1:0]            out_status;
    logic [NODE_W-1:0]     out_node;
    logic                  out_last;

    // Saturate the node count to the storage limit
    assign live_n = (node_count_reg > LIMIT_N) ? LIMIT_N : node_count_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept_in = s_valid && s_ready;
    assign idx_ok    = ({1'b0, s_node_a} < live_n) && ({1'b0, s_node_b} < live_n);
    assign found     = popped_reg && (cur_reg == target_reg);
    assign pop_done  = (count_reg == '0) || found;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_last = (({1'b0, idx_reg} + CNT_W'(1)) >= live_n);
    assign emit_more = (cur_reg != start_reg) && (k_reg != K_MAX) && !tail_reg;

    // Shared neighbour test: one column of the current row per cycle
    assign push_ok = (idx_reg != cur_reg) && adj_reg[cur_reg][idx_reg]
                     && !explored_reg[idx_reg] && !pred_valid_reg[idx_reg]
                     && (count_reg < STACK_N);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept_in) begin
                    case (s_func)
                        FN_SEARCH: state_next = idx_ok ? S_POP : S_REPORT;
                        FN_ADD:    state_next = idx_ok ? S_IDLE : S_REPORT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_POP: begin
                if (pop_done) begin
                    state_next = found ? S_EMIT : S_REPORT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    state_next = S_POP;
                end
            end
            S_EMIT: begin
                if (out_free && !emit_more) begin
                    state_next = S_IDLE;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result loading
    always_comb begin
        out_load   = 1'b0;
        out_status = ST_PATH;
        out_node   = '0;
        out_last   = 1'b1;
        case (state_reg)
            S_EMIT: begin
                out_load   = out_free;
                out_status = ST_PATH;
                out_node   = cur_reg;
                out_last   = !emit_more;
            end
            S_REPORT: begin
                out_load   = out_free;
                out_status = rep_status_reg;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Control state, marks and the matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            node_count_reg <= STACK_N;
            explored_reg   <= '0;
            pred_valid_reg <= '0;
            count_reg      <= '0;
            popped_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int r = 0; r < ADDR_NODES; r++) begin
                adj_reg[r] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end

            // Update the matrix and seed a search
            if (accept_in) begin
                if (s_func == FN_CLEAR) begin
                    for (int r = 0; r < ADDR_NODES; r++) begin
                        adj_reg[r] <= '0;
                    end
                end else if (s_func == FN_ADD && idx_ok) begin
                    adj_reg[s_node_a][s_node_b] <= 1'b1;
                    adj_reg[s_node_b][s_node_a] <= 1'b1;
                end else if (s_func == FN_SEARCH && idx_ok) begin
                    explored_reg   <= '0;
                    pred_valid_reg <= '0;
                    count_reg      <= CNT_W'(1);
                    popped_reg     <= 1'b0;
                end
            end

            // Pop the top of the stack
            if (state_reg == S_POP && !pop_done) begin
                count_reg  <= count_reg - CNT_W'(1);
                popped_reg <= 1'b1;
            end

            // Push one neighbour, mark the node explored at the end of its row
            if (state_reg == S_SCAN) begin
                if (push_ok) begin
                    count_reg               <= count_reg + CNT_W'(1);
                    pred_valid_reg[idx_reg] <= 1'b1;
                end
                if (scan_last) begin
                    explored_reg[cur_reg] <= 1'b1;
                end
            end

            // Hold the result until it is taken
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            start_reg  <= s_node_a;
            target_reg <= s_node_b;
            stack_reg[0] <= s_node_a;
            rep_status_reg <= ST_RANGE;
        end

        if (state_reg == S_POP) begin
            if (pop_done) begin
                rep_status_reg <= ST_NONE;
                k_reg          <= '0;
                tail_reg       <= 1'b0;
            end else begin
                cur_reg <= stack_reg[NODE_W'(count_reg - CNT_W'(1))];
                idx_reg <= '0;
            end
        end

        if (state_reg == S_SCAN) begin
            if (push_ok) begin
                stack_reg[count_reg[NODE_W-1:0]] <= idx_reg;
                pred_idx_reg[idx_reg]            <= cur_reg;
            end
            idx_reg <= idx_reg + NODE_W'(1);
        end

        // Walk the predecessor chain, stop at the start node, at the hop limit or where it breaks
        if (state_reg == S_EMIT && out_free && emit_more) begin
            k_reg <= k_reg + NODE_W'(1);
            if (pred_valid_reg[cur_reg]) begin
                cur_reg <= pred_idx_reg[cur_reg];
            end else begin
                tail_reg <= 1'b1;
            end
        end

        if (out_load) begin
            m_status_reg <= out_status;
            m_node_reg   <= out_node;
            m_last_reg   <= out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_path_node = m_node_reg;
    assign m_last      = m_last_reg;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top
    import dfs_pkg::*;
();

    localparam int MAX_NODES = 32;
    // Operation code that the block ignores
    localparam logic [1:0] FN_UNUSED = 2'd3;
    // Cycles to let pass after the last result before touching the register
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] node;
        logic              last;
    } path_result_t;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    // Graph model and the queue of path results still to arrive
    class path_scoreboard;
        logic [ADDR_NODES-1:0] adj_rows [ADDR_NODES];
        logic [CNT_W-1:0]      node_count;
        path_result_t          path_results [$];
        int                    errors;

        function new();
            for (int i = 0; i < ADDR_NODES; i++) adj_rows[i] = '0;
            node_count = 6'd32;
            errors     = 0;
        endfunction

        task report(string msg);
            if (errors < 60) $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return path_results.size();
        endfunction

        function void set_node_count(logic [CNT_W-1:0] value);
            node_count = value;
        endfunction

        function int live_nodes();
            int n;
            n = node_count;
            if (n > MAX_NODES) n = MAX_NODES;
            if (n > ADDR_NODES) n = ADDR_NODES;
            return n;
        endfunction

        function void queue_result(logic [1:0] status, logic [NODE_W-1:0] node, logic last);
            path_result_t r;
            r.status = status;
            r.node   = node;
            r.last   = last;
            path_results.push_back(r);
        endfunction

        // Depth-first search with an explicit stack, then walk predecessors back
        function void search_path(logic [NODE_W-1:0] start, logic [NODE_W-1:0] target,
                                  int n);
            bit                seen     [ADDR_NODES];
            bit                has_pred [ADDR_NODES];
            logic [NODE_W-1:0] pred     [ADDR_NODES];
            logic [NODE_W-1:0] stk      [ADDR_NODES];
            int                depth;
            logic [NODE_W-1:0] cur;
            bit                popped;
            int                hops;
            for (int i = 0; i < ADDR_NODES; i++) begin
                seen[i]     = 1'b0;
                has_pred[i] = 1'b0;
                pred[i]     = '0;
                stk[i]      = '0;
            end
            stk[0] = start;
            depth  = 1;
            popped = 1'b0;
            cur    = '0;
            while (depth != 0 && !(popped && cur == target)) begin
                depth--;
                cur    = stk[depth];
                popped = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (i == cur) continue;
                    if (!adj_rows[cur][i]) continue;
                    if (seen[i] || has_pred[i]) continue;
                    if (depth < ADDR_NODES) begin
                        stk[depth]  = NODE_W'(i);
                        depth++;
                        has_pred[i] = 1'b1;
                        pred[i]     = cur;
                    end
                end
                seen[cur] = 1'b1;
            end
            if (!(popped && cur == target)) begin
                queue_result(ST_NONE, '0, 1'b1);
                return;
            end
            hops = 0;
            while (cur != start && hops < ADDR_NODES - 1) begin
                queue_result(ST_PATH, cur, 1'b0);
                hops++;
                if (!has_pred[cur]) break;
                cur = pred[cur];
            end
            queue_result(ST_PATH, cur, 1'b1);
        endfunction

        function void note_input(logic [1:0] func, logic [NODE_W-1:0] a,
                                 logic [NODE_W-1:0] b);
            int n;
            n = live_nodes();
            if (func == FN_CLEAR) begin
                for (int i = 0; i < ADDR_NODES; i++) adj_rows[i] = '0;
            end else if (func == FN_UNUSED) begin
                // ignored by the block
            end else if (a >= n || b >= n) begin
                queue_result(ST_RANGE, '0, 1'b1);
            end else if (func == FN_ADD) begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
            end else begin
                search_path(a, b, n);
            end
        endfunction

        task check_result(logic [1:0] status, logic [NODE_W-1:0] node, logic last);
            path_result_t want;
            if (path_results.size() == 0) begin
                report($sformatf("unexpected result status=%0d node=%0d last=%0d",
                                 status, node, last));
                return;
            end
            want = path_results.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, want %0d", status, want.status));
            if (node !== want.node)
                report($sformatf("path_node %0d, want %0d", node, want.node));
            if (last !== want.last)
                report($sformatf("last %0d, want %0d", last, want.last));
        endtask
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data    = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [1:0]        s_func      = FN_ADD;
    logic [NODE_W-1:0] s_node_a    = '0;
    logic [NODE_W-1:0] s_node_b    = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [1:0]        m_status;
    logic [NODE_W-1:0] m_path_node;
    logic              m_last;

    path_scoreboard sb;
    int             burst_left = 0;
    rx_mode_t       rx_mode    = RX_OPEN;
    int             rx_left    = 0;
    int             rx_tick    = 0;

    dfs_path_search_adjacency_matrix #(
        .MAX_NODES(MAX_NODES)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_node_a   (s_node_a),
        .s_node_b   (s_node_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_path_node(m_path_node),
        .m_last     (m_last)
    );

    always #5 aclk = ~aclk;

    // Watch every channel and feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_node_count(cfg_data);
            if (s_valid && s_ready) sb.note_input(s_func, s_node_a, s_node_b);
            if (m_valid && m_ready) sb.check_result(m_status, m_path_node, m_last);
        end
    end

    // Result side: switch between randomly chosen stall patterns
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_COIN:     m_ready <= ($urandom_range(0, 1) == 1);
            RX_PERIODIC: m_ready <= (rx_tick % 4 == 0);
            default:     m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Hold one transaction until taken, then keep the burst or open a gap
    task automatic send_item(logic [1:0] func, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        s_valid  <= 1'b1;
        s_func   <= func;
        s_node_a <= a;
        s_node_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(logic [CNT_W-1:0] value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly a live node, now and then anything the field can carry
    function automatic logic [NODE_W-1:0] pick_node(int n);
        if (n == 0 || $urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, 31));
        return NODE_W'($urandom_range(0, n - 1));
    endfunction

    task automatic directed_items();
        // start equals target, not found, a path through a self-looped node
        send_item(FN_SEARCH, 5'd0, 5'd0);
        send_item(FN_SEARCH, 5'd0, 5'd31);
        send_item(FN_ADD, 5'd0, 5'd31);
        send_item(FN_ADD, 5'd31, 5'd31);
        send_item(FN_ADD, 5'd5, 5'd31);
        send_item(FN_SEARCH, 5'd0, 5'd5);
        send_item(FN_SEARCH, 5'd31, 5'd31);
        send_item(FN_UNUSED, 5'd31, 5'd31);
        send_item(FN_ADD, 5'd31, 5'd0);
        send_item(FN_CLEAR, 5'd31, 5'd0);
        send_item(FN_SEARCH, 5'd0, 5'd5);
        send_item(FN_ADD, 5'd0, 5'd31);
        send_item(FN_ADD, 5'd0, 5'd3);
        // small graph: stored edge to node 31 must not be scanned
        write_node_count(6'd4);
        send_item(FN_SEARCH, 5'd0, 5'd3);
        send_item(FN_ADD, 5'd2, 5'd7);
        send_item(FN_SEARCH, 5'd7, 5'd1);
        send_item(FN_SEARCH, 5'd1, 5'd4);
        send_item(FN_UNUSED, 5'd1, 5'd2);
        // no live nodes at all
        write_node_count(6'd0);
        send_item(FN_ADD, 5'd0, 5'd0);
        send_item(FN_SEARCH, 5'd0, 5'd0);
        send_item(FN_CLEAR, 5'd0, 5'd0);
        // count above the limit saturates
        write_node_count(6'd63);
        send_item(FN_SEARCH, 5'd31, 5'd0);
        send_item(FN_ADD, 5'd31, 5'd30);
        send_item(FN_SEARCH, 5'd30, 5'd31);
        write_node_count(6'd1);
        send_item(FN_SEARCH, 5'd0, 5'd0);
        send_item(FN_ADD, 5'd0, 5'd1);
    endtask

    // Build a graph, then search it; or lay a chain; or send loose noise
    task automatic random_phase(int quota);
        int                n;
        int                sent;
        int                pick;
        int                edges;
        int                j;
        logic [NODE_W-1:0] tmp;
        logic [NODE_W-1:0] perm [ADDR_NODES];
        logic [1:0]        func;
        n    = sb.live_nodes();
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_item(FN_CLEAR, pick_node(32), pick_node(32));
                    sent++;
                end
                edges = $urandom_range(1, (n < 2) ? 2 : 2 * n);
                repeat (edges) begin
                    send_item(FN_ADD, pick_node(n), pick_node(n));
                    sent++;
                end
                repeat ($urandom_range(1, 4)) begin
                    send_item(FN_SEARCH, pick_node(n), pick_node(n));
                    sent++;
                end
            end else if (pick < 75 && n >= 2) begin
                for (int i = 0; i < n; i++) perm[i] = NODE_W'(i);
                for (int i = n - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                send_item(FN_CLEAR, pick_node(32), pick_node(32));
                sent++;
                for (int i = 0; i + 1 < n; i++) begin
                    send_item(FN_ADD, perm[i], perm[i + 1]);
                    sent++;
                end
                send_item(FN_SEARCH, perm[0], perm[n - 1]);
                send_item(FN_SEARCH, pick_node(n), pick_node(n));
                sent += 2;
            end else begin
                func = 2'($urandom_range(0, 3));
                send_item(func, NODE_W'($urandom_range(0, 31)), NODE_W'($urandom_range(0, 31)));
                if (func != FN_UNUSED) sent++;
            end
            // now and then let the block drain completely
            if ($urandom_range(0, 29) == 0) wait_quiet();
        end
    endtask

    initial begin
        int phase_counts [10];
        int guard;
        phase_counts = '{32, 63, 1, 2, 8, 17, 31, 32, 3, 32};
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_items();
        foreach (phase_counts[p]) begin
            write_node_count(CNT_W'(phase_counts[p]));
            random_phase(35);
        end

        s_valid <= 1'b0;
        guard = 0;
        @(posedge aclk);
        while (sb.pending() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("ERROR: run timed out");
        $display("Simulation FAILED");
        $finish;
    end

endmodule
